[design/oss_pkg.sv]
package oss_pkg;

	localparam int unsigned SECTOR_BYTES = 2352;
	localparam int unsigned PREV_DEPTH   = 2 * SECTOR_BYTES;
	localparam int unsigned NEW_DEPTH    = 3 * SECTOR_BYTES - 1;

	localparam int unsigned ADDR_W = 13;
	localparam int unsigned OFS_W  = 12;

	localparam logic [ADDR_W-1:0] OVERLAP    = ADDR_W'(PREV_DEPTH);
	localparam logic [ADDR_W-1:0] PREV_LAST  = ADDR_W'(PREV_DEPTH - 1);
	localparam logic [ADDR_W-1:0] PREV_LIMIT = ADDR_W'(PREV_DEPTH);
	localparam logic [ADDR_W-1:0] NEW_LIMIT  = ADDR_W'(NEW_DEPTH);
	localparam logic [OFS_W-1:0]  OFS_MAX    = OFS_W'(SECTOR_BYTES - 1);
	localparam logic [16:0]       SECTOR_17  = 17'(SECTOR_BYTES);

	// input kinds
	localparam logic [1:0] OP_LOAD_PREV = 2'd0;
	localparam logic [1:0] OP_LOAD_NEW  = 2'd1;
	localparam logic [1:0] OP_SEARCH    = 2'd2;
	localparam logic [1:0] OP_CLEAR     = 2'd3;

	// result status, also the search phase while running
	localparam logic [1:0] ST_ALIGNED = 2'd0;
	localparam logic [1:0] ST_NEW_SHIFT = 2'd1;
	localparam logic [1:0] ST_PREV_SHIFT = 2'd2;
	localparam logic [1:0] ST_NO_MATCH = 2'd3;

	typedef struct packed {
		logic              prev_we;
		logic              new_we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prev_addr;
		logic [ADDR_W-1:0] new_addr;
	} rd_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFS_W-1:0]  shift;
		logic [ADDR_W-1:0] start_offset;
		logic [16:0]       payload_bytes;
		logic [15:0]       stitch_total;
		logic [15:0]       fail_total;
	} res_t;

endpackage

[design/oss_store.sv]
module oss_store (
	input  logic             clk,
	input  oss_pkg::wr_t     wr,
	input  oss_pkg::rd_req_t rd,
	output logic [7:0]       prev_rdata,
	output logic [7:0]       new_rdata
);

	logic [7:0] prev_mem [oss_pkg::PREV_DEPTH];
	logic [7:0] new_mem  [oss_pkg::NEW_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.prev_we && (wr.addr < oss_pkg::PREV_LIMIT)) begin
			prev_mem[wr.addr] <= wr.data;
		end
		prev_rdata <= prev_mem[rd.prev_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.new_we && (wr.addr < oss_pkg::NEW_LIMIT)) begin
			new_mem[wr.addr] <= wr.data;
		end
		new_rdata <= new_mem[rd.new_addr];
	end

endmodule

[design/oss_search.sv]
module oss_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       clear,
	input  logic [4:0]                 blocks,
	input  logic                       take,
	input  logic [7:0]                 prev_rdata,
	input  logic [7:0]                 new_rdata,
	output oss_pkg::rd_req_t           rd,
	output logic                       busy,
	output logic                       res_valid,
	output oss_pkg::res_t              res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [1:0]                   status_q;
	logic [oss_pkg::OFS_W-1:0]    ofs_q;
	logic [oss_pkg::ADDR_W-1:0]   idx_q;
	logic                         issuing_q;
	logic                         rd_valid_s1;
	logic                         rd_last_s1;
	logic [4:0]                   blocks_q;
	logic [15:0]                  stitch_q;
	logic [15:0]                  fail_q;

	logic [oss_pkg::ADDR_W-1:0]   ofs_ext;
	logic [oss_pkg::ADDR_W-1:0]   last_idx;
	logic                         is_last;
	logic                         byte_eq;
	logic [4:0]                   blocks_eff;
	logic [16:0]                  payload;

	assign ofs_ext = oss_pkg::ADDR_W'(ofs_q);

	// previous-window slide shrinks the compare length
	assign last_idx = (status_q == oss_pkg::ST_PREV_SHIFT) ? (oss_pkg::PREV_LAST - ofs_ext)
		: oss_pkg::PREV_LAST;
	assign is_last = (idx_q == last_idx);

	assign rd.prev_addr = (status_q == oss_pkg::ST_PREV_SHIFT) ? (idx_q + ofs_ext) : idx_q;
	assign rd.new_addr  = (status_q == oss_pkg::ST_NEW_SHIFT) ? (idx_q + ofs_ext) : idx_q;

	assign byte_eq = (prev_rdata == new_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= oss_pkg::ST_ALIGNED;
			issuing_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			stitch_q    <= '0;
			fail_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (clear) begin
						stitch_q <= '0;
						fail_q   <= '0;
					end
					if (start) begin
						state_q     <= S_RUN;
						status_q    <= oss_pkg::ST_ALIGNED;
						issuing_q   <= 1'b1;
						rd_valid_s1 <= 1'b0;
					end
				end
				S_RUN: begin
					if (issuing_q) begin
						rd_valid_s1 <= 1'b1;
						if (is_last) begin
							issuing_q <= 1'b0;
						end
					end else begin
						rd_valid_s1 <= 1'b0;
					end
					if (rd_valid_s1) begin
						if (!byte_eq) begin
							// drop the read in flight and restart at the next candidate
							rd_valid_s1 <= 1'b0;
							issuing_q   <= 1'b1;
							priority if (status_q == oss_pkg::ST_ALIGNED) begin
								status_q <= oss_pkg::ST_NEW_SHIFT;
								if (stitch_q != 16'hFFFF) begin
									stitch_q <= stitch_q + 16'd1;
								end
							end else if (ofs_q == oss_pkg::OFS_MAX) begin
								if (status_q == oss_pkg::ST_NEW_SHIFT) begin
									status_q <= oss_pkg::ST_PREV_SHIFT;
								end else begin
									status_q  <= oss_pkg::ST_NO_MATCH;
									issuing_q <= 1'b0;
									state_q   <= S_DONE;
									if (fail_q != 16'hFFFF) begin
										fail_q <= fail_q + 16'd1;
									end
								end
							end else begin
								// same phase, the datapath steps the offset
							end
						end else if (rd_last_s1) begin
							rd_valid_s1 <= 1'b0;
							issuing_q   <= 1'b0;
							state_q     <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			ofs_q    <= '0;
			idx_q    <= '0;
			blocks_q <= blocks;
		end else if (state_q == S_RUN) begin
			if (issuing_q) begin
				rd_last_s1 <= is_last;
				if (!is_last) begin
					idx_q <= idx_q + oss_pkg::ADDR_W'(1);
				end
			end
			if (rd_valid_s1 && !byte_eq) begin
				idx_q <= '0;
				if ((status_q == oss_pkg::ST_ALIGNED) || (ofs_q == oss_pkg::OFS_MAX)) begin
					ofs_q <= oss_pkg::OFS_W'(1);
				end else begin
					ofs_q <= ofs_q + oss_pkg::OFS_W'(1);
				end
			end
		end
	end

	// new-data slide drops one sector, saturating at zero
	assign blocks_eff = ((status_q == oss_pkg::ST_NEW_SHIFT) && (blocks_q != 5'd0))
		? (blocks_q - 5'd1)
		: ((status_q == oss_pkg::ST_NEW_SHIFT) ? 5'd0 : blocks_q);
	assign payload = 17'(blocks_eff) * oss_pkg::SECTOR_17;

	always_comb begin
		res.status       = status_q;
		res.stitch_total = stitch_q;
		res.fail_total   = fail_q;
		unique case (status_q)
			oss_pkg::ST_ALIGNED: begin
				res.shift         = '0;
				res.start_offset  = oss_pkg::OVERLAP;
				res.payload_bytes = payload;
			end
			oss_pkg::ST_NEW_SHIFT: begin
				res.shift         = ofs_q;
				res.start_offset  = oss_pkg::OVERLAP + ofs_ext;
				res.payload_bytes = payload;
			end
			oss_pkg::ST_PREV_SHIFT: begin
				res.shift         = ofs_q;
				res.start_offset  = oss_pkg::OVERLAP - ofs_ext;
				res.payload_bytes = payload;
			end
			default: begin
				res.shift         = '0;
				res.start_offset  = '0;
				res.payload_bytes = '0;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);

endmodule

[design/overlap_stitch_search_core.sv]
// channel  dir  tdata (low bit up)                          tuser
// s_*      in   index[12:0] data[20:13] block_count[25:21]  op
// m_*      out  shift[11:0] start_offset[24:12]             status
//               payload_bytes[41:25] stitch_total[57:42]
//               fail_total[73:58]
// loads and clears give no result beat; reset clears control and counters, store
// contents are undefined until loaded.
// a search compares one byte pair a cycle within a candidate; a mismatch drops the read
// in flight and restarts at the next candidate. s_tready stays low during a search and
// while its result waits for the full output register to drain.
module overlap_stitch_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // index, data, block_count
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // shift, start_offset, payload_bytes, stitch_total, fail_total
	output logic [1:0]  m_tuser    // status
);

	logic             s_beat;
	logic             busy;
	logic             res_valid;
	logic             take;
	logic             out_valid_q;
	oss_pkg::res_t    res;
	oss_pkg::res_t    out_q;
	oss_pkg::wr_t     wr;
	oss_pkg::rd_req_t rd;
	logic [7:0]       prev_rdata;
	logic [7:0]       new_rdata;

	assign s_tready = !busy;
	assign s_beat   = s_tvalid && s_tready;

	assign wr.prev_we = s_beat && (s_tuser == oss_pkg::OP_LOAD_PREV);
	assign wr.new_we  = s_beat && (s_tuser == oss_pkg::OP_LOAD_NEW);
	assign wr.addr    = s_tdata[12:0];
	assign wr.data    = s_tdata[20:13];

	oss_store u_store (
		.clk        (clk),
		.wr         (wr),
		.rd         (rd),
		.prev_rdata (prev_rdata),
		.new_rdata  (new_rdata)
	);

	oss_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_beat && (s_tuser == oss_pkg::OP_SEARCH)),
		.clear      (s_beat && (s_tuser == oss_pkg::OP_CLEAR)),
		.blocks     (s_tdata[25:21]),
		.take       (take),
		.prev_rdata (prev_rdata),
		.new_rdata  (new_rdata),
		.rd         (rd),
		.busy       (busy),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {6'd0, out_q.fail_total, out_q.stitch_total, out_q.payload_bytes,
		out_q.start_offset, out_q.shift};

	no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == oss_pkg::ST_NO_MATCH)) |-> (m_tdata[41:0] == 42'd0))
		else $error("no-match result carries nonzero fields");

	aligned_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == oss_pkg::ST_ALIGNED))
		|-> ((m_tdata[11:0] == 12'd0) && (m_tdata[24:12] == oss_pkg::OVERLAP)))
		else $error("aligned result has wrong shift or start");

	fail_le_stitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[73:58] <= m_tdata[57:42]))
		else $error("fail count exceeds stitch count");

	busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == oss_pkg::OP_SEARCH)) |=> !s_tready)
		else $error("search accepted but block not busy");

endmodule
